// File: src/gas_pkg.sv
// Shared types, constants and saturating arithmetic for the global alignment score block.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps

package gas_pkg;

  localparam int MAX_QUERY = 1024;
  localparam int SCORE_W   = 24;
  localparam int SUM_W     = SCORE_W + 2;
  localparam int SYM_W     = 8;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int BUSY_W    = $clog2(MAX_QUERY + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd2;

  localparam logic OP_QUERY   = 1'b0;
  localparam logic OP_SUBJECT = 1'b1;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [CFG_W-1:0]   coef_t;
  typedef logic [SYM_W-1:0]          sym_t;

  typedef struct packed {
    coef_t gap;
    coef_t match;
    coef_t mismatch;
  } cfg_t;

  // Query load command broadcast to every cell.
  typedef struct packed {
    logic wr;
    logic restart;
    sym_t sym;
  } ld_t;

  // One subject row travelling down the chain.
  typedef struct packed {
    logic   vld;
    logic   first;
    logic   last;
    sym_t   sym;
    score_t left;
    score_t diag;
  } beat_t;

  function automatic score_t sat_score(input sum_t v);
    score_t r;
    if (v > sum_t'(SCORE_MAX)) begin
      r = SCORE_MAX;
    end else if (v < sum_t'(SCORE_MIN)) begin
      r = SCORE_MIN;
    end else begin
      r = v[SCORE_W-1:0];
    end
    return r;
  endfunction

  function automatic score_t add_sat(input score_t a, input coef_t b);
    sum_t s;
    s = sum_t'(a) + sum_t'(b);
    return sat_score(s);
  endfunction

endpackage

// File: src/gas_cell.sv
// One processing cell of the alignment chain: holds one query symbol and one column score.
// Depends on gas_pkg for the beat, load and configuration types.
`timescale 1ns / 1ps

module gas_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  gas_pkg::cfg_t cfg,
  input  gas_pkg::ld_t  ld,
  input  logic          prev_filled,
  output logic          filled,
  input  gas_pkg::beat_t beat_in,
  output gas_pkg::beat_t beat_out
);

  gas_pkg::sym_t   qsym;
  gas_pkg::score_t up;
  gas_pkg::score_t up_val;
  gas_pkg::score_t h_val;
  gas_pkg::sum_t   d_sum;
  gas_pkg::sum_t   u_sum;
  gas_pkg::sum_t   l_sum;
  gas_pkg::sum_t   best;
  gas_pkg::coef_t  sub;
  gas_pkg::beat_t  beat_next;
  logic            own;
  logic            wr_here;

  // Query loading: the first cell whose predecessor is filled takes the symbol.
  assign own     = filled & ~ld.restart;
  assign wr_here = ld.wr & prev_filled & ~own;

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
    end else if (ld.wr) begin
      filled <= own | wr_here;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      qsym <= ld.sym;
    end
  end

  // On the first row of a subject the score above is the top boundary, built from the
  // boundary value that the previous cell hands down as the diagonal.
  always_comb begin
    up_val = beat_in.first ? gas_pkg::add_sat(beat_in.diag, cfg.gap) : up;
    sub    = (qsym == beat_in.sym) ? cfg.match : cfg.mismatch;
    d_sum  = gas_pkg::sum_t'(beat_in.diag) + gas_pkg::sum_t'(sub);
    u_sum  = gas_pkg::sum_t'(up_val) + gas_pkg::sum_t'(cfg.gap);
    l_sum  = gas_pkg::sum_t'(beat_in.left) + gas_pkg::sum_t'(cfg.gap);
    best   = (d_sum > u_sum) ? d_sum : u_sum;
    best   = (l_sum > best) ? l_sum : best;
    h_val  = gas_pkg::sat_score(best);

    beat_next = beat_in;
    if (filled) begin
      beat_next.left = h_val;
      beat_next.diag = up_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && beat_in.vld && filled) begin
      up <= h_val;
    end
  end

  // Only the valid bit is reset; the data fields simply follow the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.vld <= 1'b0;
    end else if (adv) begin
      beat_out.vld <= beat_next.vld;
    end
    if (adv) begin
      beat_out.first <= beat_next.first;
      beat_out.last  <= beat_next.last;
      beat_out.sym   <= beat_next.sym;
      beat_out.left  <= beat_next.left;
      beat_out.diag  <= beat_next.diag;
    end
  end

endmodule

// File: src/gas_chain.sv
// The systolic row of alignment cells, one per query position.
// Depends on gas_pkg and gas_cell.
`timescale 1ns / 1ps

module gas_chain (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  gas_pkg::cfg_t  cfg,
  input  gas_pkg::ld_t   ld,
  input  gas_pkg::beat_t beat_in,
  output gas_pkg::beat_t beat_out
);

  gas_pkg::beat_t                  beats [0:gas_pkg::MAX_QUERY];
  logic [gas_pkg::MAX_QUERY-1:0]   filled;
  logic [gas_pkg::MAX_QUERY-1:0]   prev_eff;

  assign beats[0] = beat_in;
  assign beat_out = beats[gas_pkg::MAX_QUERY];

  // A restart empties every cell but the first, which takes the new symbol.
  assign prev_eff[0] = 1'b1;

  for (genvar j = 0; j < gas_pkg::MAX_QUERY; j++) begin : g_cell
    if (j > 0) begin : g_prev
      assign prev_eff[j] = filled[j-1] & ~ld.restart;
    end
    gas_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .adv         (adv),
      .cfg         (cfg),
      .ld          (ld),
      .prev_filled (prev_eff[j]),
      .filled      (filled[j]),
      .beat_in     (beats[j]),
      .beat_out    (beats[j+1])
    );
  end

endmodule

// File: src/global_alignment_score.sv
// Global alignment score: the beat of the last subject symbol passes the register of every
// cell in the chain, then the output register, before its score reaches the result port.
// While no pending result stalls the chain, subject symbols are taken one per cycle and
// the whole chain moves one cell per cycle; a query symbol waits until no subject row is left.
// Reset (rst, synchronous) empties the query, drops rows in flight and restores the
// configuration registers to gap -1, match 1 and mismatch -1.
`timescale 1ns / 1ps

module global_alignment_score (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gas_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               opcode,
  input  logic [gas_pkg::SYM_W-1:0]          symbol,
  input  logic                               last,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [gas_pkg::SCORE_W-1:0] score
);

  gas_pkg::cfg_t   cfg;
  gas_pkg::ld_t    ld;
  gas_pkg::beat_t  entry;
  gas_pkg::beat_t  exit_beat;
  gas_pkg::score_t left_col;
  gas_pkg::score_t up0;
  gas_pkg::score_t left0;
  logic [gas_pkg::BUSY_W-1:0] busy;
  logic [gas_pkg::BUSY_W-1:0] busy_next;
  logic            first_row;
  logic            loading_done;
  logic            adv;
  logic            accept;
  logic            take_subject;
  logic            take_query;
  logic            exit_result;

  // Configuration registers. Writes to an index past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap      <= -6'sd1;
      cfg.match    <= 6'sd1;
      cfg.mismatch <= -6'sd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gas_pkg::CFG_GAP:      cfg.gap      <= cfg_data;
        gas_pkg::CFG_MATCH:    cfg.match    <= cfg_data;
        gas_pkg::CFG_MISMATCH: cfg.mismatch <= cfg_data;
        default: ;
      endcase
    end
  end

  // The chain moves every cycle unless a finished score would overrun a result that the
  // downstream side has not taken yet.
  assign exit_result = exit_beat.vld & exit_beat.last;
  assign adv         = ~(exit_result & result_valid & result_stall);

  // A query symbol rewrites the cells, so it waits until every subject row has left.
  assign item_stall   = ~adv | ((opcode == gas_pkg::OP_QUERY) & (busy != '0));
  assign accept       = item_valid & ~item_stall;
  assign take_subject = accept & (opcode == gas_pkg::OP_SUBJECT);
  assign take_query   = accept & (opcode == gas_pkg::OP_QUERY);

  // The left column of the score matrix is kept here: column zero of the new row is the
  // one above plus a gap, starting from zero on the first row of a subject.
  assign up0   = first_row ? '0 : left_col;
  assign left0 = gas_pkg::add_sat(up0, cfg.gap);

  always_comb begin
    entry.vld   = take_subject;
    entry.first = first_row;
    entry.last  = last;
    entry.sym   = symbol;
    entry.left  = left0;
    entry.diag  = up0;
  end

  assign ld.wr      = take_query;
  assign ld.restart = loading_done;
  assign ld.sym     = symbol;

  always_ff @(posedge clk) begin
    if (take_subject) begin
      left_col <= left0;
    end
  end

  // A subject symbol ends loading; a query symbol after that starts a new query and a
  // fresh subject. The last subject symbol brings the row back to the top boundary.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_row    <= 1'b1;
      loading_done <= 1'b0;
    end else if (take_subject) begin
      first_row    <= last;
      loading_done <= 1'b1;
    end else if (take_query) begin
      if (loading_done) begin
        first_row <= 1'b1;
      end
      loading_done <= last;
    end
  end

  // Count of subject rows inside the chain.
  always_comb begin
    busy_next = busy;
    if (take_subject) begin
      busy_next = busy_next + 1'b1;
    end
    if (adv && exit_beat.vld) begin
      busy_next = busy_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      busy <= busy_next;
    end
  end

  gas_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cfg      (cfg),
    .ld       (ld),
    .beat_in  (entry),
    .beat_out (exit_beat)
  );

  // Output register. Past the last query cell a row is carried unchanged, so its left
  // value at the end of the chain is the corner score.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && exit_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && exit_result) begin
      score <= exit_beat.left;
    end
  end

`ifndef SYNTHESIS
  a_busy_bound: assert property (@(posedge clk) disable iff (rst)
    busy <= gas_pkg::BUSY_W'(gas_pkg::MAX_QUERY))
    else $error("row count exceeds chain depth");

  a_empty_chain: assert property (@(posedge clk) disable iff (rst)
    (busy == '0) |-> !exit_beat.vld)
    else $error("row leaves an empty chain");

  a_query_idle: assert property (@(posedge clk) disable iff (rst)
    take_query |=> (busy == '0))
    else $error("query load overlapped subject rows");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall && exit_result) |=> $stable(score))
    else $error("pending score overwritten");
`endif

endmodule
